@@ src/mtep_pkg.sv @@
// Shared types and constants for the MIDI track event parser.
package mtep_pkg;

	localparam int DELTA_BYTES = 4;
	localparam int DELTA_W     = 28;
	localparam int CNT_W       = $clog2(DELTA_BYTES + 1);

	localparam logic [2:0] PH_DELTA  = 3'd0;
	localparam logic [2:0] PH_STATUS = 3'd1;
	localparam logic [2:0] PH_NOTE   = 3'd2;
	localparam logic [2:0] PH_VEL    = 3'd3;
	localparam logic [2:0] PH_SKIP   = 3'd4;
	localparam logic [2:0] PH_MTYPE  = 3'd5;
	localparam logic [2:0] PH_LEN    = 3'd6;

	localparam logic [3:0] HI_NOTE_OFF = 4'h8;
	localparam logic [3:0] HI_NOTE_ON  = 4'h9;
	localparam logic [3:0] HI_POLY_AT  = 4'hA;
	localparam logic [3:0] HI_CTRL     = 4'hB;
	localparam logic [3:0] HI_PROGRAM  = 4'hC;
	localparam logic [3:0] HI_CHAN_AT  = 4'hD;
	localparam logic [3:0] HI_BEND     = 4'hE;

	localparam logic [7:0] META_STATUS   = 8'hFF;
	localparam logic [7:0] META_END_TYPE = 8'h2F;

	localparam logic KIND_NOTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [6:0]         note_number;
		logic [6:0]         velocity;
		logic               note_on;
		logic [DELTA_W-1:0] delta_ticks;
	} event_t;

	typedef struct packed {
		logic res_valid;
		logic ended;
	} dec_status_t;

endpackage

@@ src/mtep_if.sv @@
// Handshake channels for track bytes and parsed events.
interface mtep_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] track_byte;

	modport source (output valid, output track_byte, input ready);
	modport sink   (input valid, input track_byte, output ready);
endinterface

interface mtep_event_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [6:0]  note_number;
	logic [6:0]  velocity;
	logic        note_on;
	logic [27:0] delta_ticks;

	modport source (output valid, output kind, output note_number, output velocity,
		output note_on, output delta_ticks, input ready);
	modport sink   (input valid, input kind, input note_number, input velocity,
		input note_on, input delta_ticks, output ready);
endinterface

@@ src/mtep_decoder.sv @@
// Parser state and byte decode: one byte is consumed per step.
module mtep_decoder
	import mtep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_in,
	output dec_status_t status,
	output event_t      res
);

	logic [2:0]         phase_q, phase_d;
	logic [DELTA_W-1:0] acc_q, acc_d, acc_base;
	logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_inc;
	logic               run_on_q, run_on_d;
	logic               kind_on_q, kind_on_d;
	logic [6:0]         note_q, note_d;
	logic [7:0]         skip_q, skip_d;
	logic               meta_end_q, meta_end_d;
	logic               ended_q, ended_d;
	logic [3:0]         hi;

	assign hi       = byte_in[7:4];
	assign acc_base = (cnt_q == '0) ? '0 : acc_q;
	assign cnt_inc  = cnt_q + CNT_W'(1);

	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		cnt_d      = cnt_q;
		run_on_d   = run_on_q;
		kind_on_d  = kind_on_q;
		note_d     = note_q;
		skip_d     = skip_q;
		meta_end_d = meta_end_q;
		ended_d    = ended_q;
		if (!ended_q) begin
			unique case (phase_q)
				PH_DELTA: begin
					acc_d = {acc_base[DELTA_W-8:0], byte_in[6:0]};
					cnt_d = cnt_inc;
					if (!byte_in[7] || cnt_inc >= CNT_W'(DELTA_BYTES)) begin
						cnt_d   = '0;
						phase_d = PH_STATUS;
					end
				end
				PH_STATUS: begin
					priority if (!byte_in[7]) begin
						kind_on_d = run_on_q;
						note_d    = byte_in[6:0];
						phase_d   = PH_VEL;
					end else if (hi == HI_NOTE_ON || hi == HI_NOTE_OFF) begin
						run_on_d  = (hi == HI_NOTE_ON);
						kind_on_d = (hi == HI_NOTE_ON);
						phase_d   = PH_NOTE;
					end else if (hi == HI_POLY_AT || hi == HI_CTRL || hi == HI_BEND) begin
						skip_d  = 8'd2;
						phase_d = PH_SKIP;
					end else if (hi == HI_PROGRAM || hi == HI_CHAN_AT) begin
						skip_d  = 8'd1;
						phase_d = PH_SKIP;
					end else if (byte_in == META_STATUS) begin
						phase_d = PH_MTYPE;
					end else begin
						meta_end_d = 1'b0;
						phase_d    = PH_LEN;
					end
				end
				PH_NOTE: begin
					note_d  = byte_in[6:0];
					phase_d = PH_VEL;
				end
				PH_VEL: begin
					phase_d = PH_DELTA;
				end
				PH_SKIP: begin
					skip_d = skip_q - 8'd1;
					if (skip_q == 8'd1) begin
						phase_d = PH_DELTA;
					end
				end
				PH_MTYPE: begin
					meta_end_d = (byte_in == META_END_TYPE);
					phase_d    = PH_LEN;
				end
				PH_LEN: begin
					if (meta_end_q) begin
						ended_d    = 1'b1;
						meta_end_d = 1'b0;
						phase_d    = PH_DELTA;
					end else begin
						skip_d  = byte_in;
						phase_d = (byte_in == 8'd0) ? PH_DELTA : PH_SKIP;
					end
				end
				default: begin
					phase_d = PH_DELTA;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DELTA;
			acc_q      <= '0;
			cnt_q      <= '0;
			run_on_q   <= 1'b0;
			kind_on_q  <= 1'b0;
			note_q     <= '0;
			skip_q     <= '0;
			meta_end_q <= 1'b0;
			ended_q    <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			acc_q      <= acc_d;
			cnt_q      <= cnt_d;
			run_on_q   <= run_on_d;
			kind_on_q  <= kind_on_d;
			note_q     <= note_d;
			skip_q     <= skip_d;
			meta_end_q <= meta_end_d;
			ended_q    <= ended_d;
		end
	end

	always_comb begin
		status.ended     = ended_q;
		status.res_valid = !ended_q && ((phase_q == PH_VEL) || (phase_q == PH_LEN && meta_end_q));
		res.delta_ticks  = acc_q;
		if (phase_q == PH_VEL) begin
			res.kind        = KIND_NOTE;
			res.note_number = note_q;
			res.velocity    = byte_in[6:0];
			res.note_on     = kind_on_q && (byte_in[6:0] != 7'd0);
		end else begin
			res.kind        = KIND_END;
			res.note_number = '0;
			res.velocity    = '0;
			res.note_on     = 1'b0;
		end
	end

endmodule

@@ src/midi_track_event_parser_unit.sv @@
// Top level of the MIDI track event parser: input register, decoder, result register.
// An accepted byte is held in the input register and decoded from there; a result is
// loaded into the result register and is then valid on the output.
// Throughput is one byte per cycle while the result register is free or being drained.
// Reset clears the parser state and both valid bits; the parser then expects a delta time.
module midi_track_event_parser_unit
	import mtep_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	mtep_byte_if.sink           track,
	mtep_event_if.source        events
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	event_t      out_q;
	dec_status_t dec_status;
	event_t      dec_res;
	logic        out_free;
	logic        advance;
	logic        load;

	assign out_free    = !out_valid_q || events.ready;
	assign advance     = valid_s1 && (!dec_status.res_valid || out_free);
	assign load        = advance && dec_status.res_valid;
	assign track.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (track.ready) begin
			valid_s1 <= track.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (track.ready && track.valid) begin
			byte_s1 <= track.track_byte;
		end
	end

	mtep_decoder u_decoder (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_in (byte_s1),
		.status  (dec_status),
		.res     (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= dec_res;
		end
	end

	assign events.valid       = out_valid_q;
	assign events.kind        = out_q.kind;
	assign events.note_number = out_q.note_number;
	assign events.velocity    = out_q.velocity;
	assign events.note_on     = out_q.note_on;
	assign events.delta_ticks = out_q.delta_ticks;

	a_ended_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		dec_status.ended |=> dec_status.ended)
		else $error("Track end flag cleared without reset.");

	a_no_result_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.ready && events.kind |=> !events.valid)
		else $error("Result issued after the end of track.");

	a_rise_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(events.valid) |-> $past(load))
		else $error("Output valid rose without a decoded result.");

endmodule

@@ test/midi_track_event_parser_unit_tb.sv @@
// Self-checking testbench that feeds MIDI track bytes to the event parser and checks its events.
`timescale 1ns / 100ps

module midi_track_event_parser_unit_tb;
	import mtep_pkg::*;

	localparam logic [3:0] HI_SYSTEM   = 4'hF;
	localparam int         IDLE_LIMIT  = 2000;
	localparam int         LONG_HOLD   = 300;
	localparam int         RANDOM_STOP = 1480;
	localparam int         TAIL_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n;

	mtep_byte_if  byte_ch ();
	mtep_event_if evt_ch ();

	midi_track_event_parser_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.track  (byte_ch),
		.events (evt_ch)
	);

	always #5 clk = ~clk;

	// Parser state as predicted from the accepted bytes.
	logic [2:0]         ph;
	logic [DELTA_W-1:0] acc;
	int                 dcount;
	logic               run_on;
	logic               cur_on;
	logic [6:0]         pend_note;
	logic [7:0]         skip_left;
	logic               end_meta;
	logic               ended;

	event_t      pending_events[$];
	int          mismatch_count = 0;
	int          bytes_sent = 0;
	int          idle_cycles = 0;
	bit          sender_gaps = 1'b1;
	bit          receiver_gaps = 1'b1;
	bit          end_allowed = 1'b0;
	int unsigned event_hold = 0;

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic void decode_track_byte(input logic [7:0] b);
		event_t     res;
		logic [6:0] vel;
		res = '0;
		if (ended)
			return;
		case (ph)
			PH_DELTA: begin
				if (dcount == 0)
					acc = '0;
				acc = {acc[DELTA_W-8:0], b[6:0]};
				dcount++;
				if (!b[7] || dcount >= DELTA_BYTES) begin
					dcount = 0;
					ph = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (!b[7]) begin
					cur_on = run_on;
					pend_note = b[6:0];
					ph = PH_VEL;
				end else if (b[7:4] == HI_NOTE_ON || b[7:4] == HI_NOTE_OFF) begin
					run_on = (b[7:4] == HI_NOTE_ON);
					cur_on = run_on;
					ph = PH_NOTE;
				end else if (b[7:4] == HI_POLY_AT || b[7:4] == HI_CTRL || b[7:4] == HI_BEND) begin
					skip_left = 8'd2;
					ph = PH_SKIP;
				end else if (b[7:4] == HI_PROGRAM || b[7:4] == HI_CHAN_AT) begin
					skip_left = 8'd1;
					ph = PH_SKIP;
				end else if (b == META_STATUS) begin
					ph = PH_MTYPE;
				end else begin
					end_meta = 1'b0;
					ph = PH_LEN;
				end
			end
			PH_NOTE: begin
				pend_note = b[6:0];
				ph = PH_VEL;
			end
			PH_VEL: begin
				vel = b[6:0];
				res.kind = KIND_NOTE;
				res.note_number = pend_note;
				res.velocity = vel;
				res.note_on = cur_on && (vel != 7'd0);
				res.delta_ticks = acc;
				pending_events.push_back(res);
				ph = PH_DELTA;
			end
			PH_SKIP: begin
				skip_left = skip_left - 8'd1;
				if (skip_left == 8'd0)
					ph = PH_DELTA;
			end
			PH_MTYPE: begin
				end_meta = (b == META_END_TYPE);
				ph = PH_LEN;
			end
			PH_LEN: begin
				if (end_meta) begin
					ended = 1'b1;
					end_meta = 1'b0;
					ph = PH_DELTA;
					res.kind = KIND_END;
					res.delta_ticks = acc;
					pending_events.push_back(res);
				end else begin
					skip_left = b;
					ph = (b == 8'd0) ? PH_DELTA : PH_SKIP;
				end
			end
			default: begin
				ph = PH_DELTA;
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] value);
		int unsigned pause;
		logic [7:0]  b;
		b = value;
		// Keep random data from closing the track before the final test.
		if (!end_allowed && ph == PH_MTYPE && b == META_END_TYPE)
			b = META_END_TYPE ^ 8'h01;
		pause = sender_gaps ? $urandom_range(0, 3) : 0;
		if (pause > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		byte_ch.valid      <= 1'b1;
		byte_ch.track_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		decode_track_byte(b);
		bytes_sent++;
	endtask

	task automatic align_to_event_start();
		while (ph != PH_DELTA || dcount != 0)
			send_byte(8'h00);
	endtask

	task automatic send_random_delta();
		int         n;
		logic [7:0] b;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, DELTA_BYTES) : 1;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(0, 127));
			if (i < n - 1)
				b[7] = 1'b1;
			else if (n == DELTA_BYTES)
				b[7] = 1'($urandom_range(0, 1));
			send_byte(b);
		end
	endtask

	task automatic send_payload(input int count);
		for (int i = 0; i < count; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_random_message();
		int         sel;
		int         len;
		logic [7:0] b;
		sel = $urandom_range(0, 99);
		if (sel >= 95) begin
			send_payload($urandom_range(1, 3));
			return;
		end
		send_random_delta();
		len = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
		if (sel < 40) begin
			send_byte({($urandom_range(0, 1) ? HI_NOTE_ON : HI_NOTE_OFF),
				4'($urandom_range(0, 15))});
			send_byte(8'($urandom_range(0, 255)));
			send_byte(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
		end else if (sel < 60) begin
			send_byte(8'($urandom_range(0, 127)));
			send_byte(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
		end else if (sel < 72) begin
			case ($urandom_range(0, 2))
				0: b = {HI_POLY_AT, 4'($urandom_range(0, 15))};
				1: b = {HI_CTRL, 4'($urandom_range(0, 15))};
				default: b = {HI_BEND, 4'($urandom_range(0, 15))};
			endcase
			send_byte(b);
			send_payload(2);
		end else if (sel < 80) begin
			send_byte({($urandom_range(0, 1) ? HI_PROGRAM : HI_CHAN_AT),
				4'($urandom_range(0, 15))});
			send_payload(1);
		end else if (sel < 88) begin
			send_byte({HI_SYSTEM, 4'($urandom_range(0, 14))});
			send_byte(8'(len));
			send_payload(len);
		end else begin
			send_byte(META_STATUS);
			send_byte(8'($urandom_range(0, 255)));
			send_byte(8'(len));
			send_payload(len);
		end
	endtask

	task automatic test_running_status_from_reset();
		send_byte(8'h00);
		send_byte(8'h3C);
		send_byte(8'h40);
	endtask

	task automatic test_delta_extremes();
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte({HI_NOTE_ON, 4'hF});
		send_byte(8'h7F);
		send_byte(8'h7F);
	endtask

	task automatic test_note_messages();
		send_byte(8'h00);
		send_byte({HI_NOTE_OFF, 4'hF});
		send_byte(8'h7F);
		send_byte(8'h7F);
		send_byte(8'h00);
		send_byte(8'h05);
		send_byte(8'h21);
		send_byte(8'h00);
		send_byte({HI_NOTE_ON, 4'h0});
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h81);
		send_byte(8'h00);
		send_byte({HI_NOTE_ON, 4'h1});
		send_byte(8'hBC);
		send_byte(8'hC0);
	endtask

	task automatic test_channel_skips();
		send_byte(8'h00);
		send_byte({HI_POLY_AT, 4'h1});
		send_payload(2);
		send_byte(8'h00);
		send_byte({HI_CTRL, 4'h2});
		send_payload(2);
		send_byte(8'h00);
		send_byte({HI_BEND, 4'h3});
		send_payload(2);
		send_byte(8'h00);
		send_byte({HI_PROGRAM, 4'h4});
		send_payload(1);
		send_byte(8'h00);
		send_byte({HI_CHAN_AT, 4'h5});
		send_payload(1);
		// Running status still refers to the last note message.
		send_byte(8'h00);
		send_byte(8'h45);
		send_byte(8'h50);
	endtask

	task automatic test_system_and_meta();
		send_byte(8'h00);
		send_byte({HI_SYSTEM, 4'h0});
		send_byte(8'h02);
		send_payload(2);
		send_byte(8'h00);
		send_byte({HI_SYSTEM, 4'hE});
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(META_STATUS);
		send_byte(8'h51);
		send_byte(8'h03);
		send_payload(3);
	endtask

	task automatic test_random_track();
		int stretch;
		while (bytes_sent < RANDOM_STOP) begin
			stretch = (bytes_sent / 250) % 5;
			sender_gaps = (stretch != 2) && (stretch != 4);
			receiver_gaps = (stretch != 2);
			send_random_message();
		end
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		align_to_event_start();
	endtask

	task automatic test_output_backpressure();
		sender_gaps = 1'b0;
		event_hold = LONG_HOLD;
		for (int i = 0; i < 12; i++) begin
			send_byte(8'h00);
			send_byte({HI_NOTE_ON, 4'($urandom_range(0, 15))});
			send_byte(8'($urandom_range(0, 127)));
			send_byte(8'($urandom_range(1, 127)));
		end
		sender_gaps = 1'b1;
	endtask

	task automatic test_end_of_track();
		end_allowed = 1'b1;
		send_byte(8'h83);
		send_byte(8'h00);
		send_byte(META_STATUS);
		send_byte(META_END_TYPE);
		send_byte(8'h85);
		// Everything after the end marker is dropped.
		send_byte(8'h00);
		send_byte({HI_NOTE_ON, 4'h0});
		send_byte(8'h3C);
		send_byte(8'h40);
	endtask

	initial begin : event_sink
		int unsigned pause;
		evt_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (event_hold > 0) begin
				pause = event_hold;
				event_hold = 0;
			end else begin
				pause = receiver_gaps ? $urandom_range(0, 3) : 0;
			end
			if (pause > 0) begin
				evt_ch.ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			evt_ch.ready <= 1'b1;
			do @(posedge clk); while (!evt_ch.valid);
		end
	end

	always @(posedge clk) begin : event_check
		event_t want;
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			if (pending_events.size() == 0) begin
				report_error($sformatf("event with none expected: kind %0d note %0d delta %0d",
					evt_ch.kind, evt_ch.note_number, evt_ch.delta_ticks));
			end else begin
				want = pending_events.pop_front();
				if (evt_ch.kind !== want.kind)
					report_error($sformatf("kind %0d, expected %0d", evt_ch.kind, want.kind));
				if (evt_ch.note_number !== want.note_number)
					report_error($sformatf("note_number %0d, expected %0d",
						evt_ch.note_number, want.note_number));
				if (evt_ch.velocity !== want.velocity)
					report_error($sformatf("velocity %0d, expected %0d",
						evt_ch.velocity, want.velocity));
				if (evt_ch.note_on !== want.note_on)
					report_error($sformatf("note_on %0d, expected %0d",
						evt_ch.note_on, want.note_on));
				if (evt_ch.delta_ticks !== want.delta_ticks)
					report_error($sformatf("delta_ticks %0h, expected %0h",
						evt_ch.delta_ticks, want.delta_ticks));
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (evt_ch.valid && evt_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		ph = PH_DELTA;
		acc = '0;
		dcount = 0;
		run_on = 1'b0;
		cur_on = 1'b0;
		pend_note = '0;
		skip_left = '0;
		end_meta = 1'b0;
		ended = 1'b0;
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.track_byte <= 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_running_status_from_reset();
		test_delta_extremes();
		test_note_messages();
		test_channel_skips();
		test_system_and_meta();
		test_random_track();
		test_output_backpressure();
		test_end_of_track();

		byte_ch.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
